// ----- rtl/rhc_pkg.sv -----
// Package for the RGB to HSV converter: payload types, hue sector codes,
// fixed-point constants and pipeline widths. No dependencies.
`default_nettype none

package rhc_pkg;

    localparam int CH_W   = 8;   // channel byte
    localparam int HUE_W  = 15;  // hue, degrees * 64
    localparam int HQ_W   = 12;  // hue quotient bits, max 3840
    localparam int SQ_W   = 8;   // saturation quotient bits
    localparam int HREM_W = 20;  // hue dividend, max 255 * 3840
    localparam int SREM_W = 16;  // saturation dividend, max 255 * 255

    localparam logic [HUE_W-1:0] HUE_FULL       = 15'd23040;
    localparam logic [HUE_W-1:0] HUE_GREEN_BASE = 15'd7680;
    localparam logic [HUE_W-1:0] HUE_BLUE_BASE  = 15'd15360;

    typedef enum logic [1:0] {
        SEC_RED,
        SEC_GREEN,
        SEC_BLUE
    } t_sector;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } t_rgb;

    typedef struct packed {
        logic [HUE_W-1:0] hue_deg_q6;
        logic [CH_W-1:0]  saturation;
        logic [CH_W-1:0]  brightness;
        logic             hue_undefined;
    } t_hsv;

    typedef struct packed {
        logic [CH_W-1:0] mx;
        logic [CH_W-1:0] delta;
        logic [CH_W-1:0] mag;     // |hue difference|
        logic            neg;     // hue difference below zero
        t_sector         sector;
    } t_sort;

    typedef struct packed {
        logic [HREM_W-1:0] rem_h;
        logic [SREM_W-1:0] rem_s;
        logic [HQ_W-1:0]   q_h;
        logic [SQ_W-1:0]   q_s;
        logic [CH_W-1:0]   den_h;  // delta
        logic [CH_W-1:0]   den_s;  // max, also the value output
        logic              neg;
        t_sector           sector;
    } t_div;

endpackage

`default_nettype wire

// ----- rtl/rhc_stream_if.sv -----
// Valid/ready stream channel for the RGB to HSV converter.
// Payload type is set per instance; no other dependencies.
`default_nettype none

interface rhc_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/rgb_to_hsv_converter_core.sv -----
// RGB to HSV converter top level: sort stage, dividend stage, restoring
// divider stages and hue assembly. Uses rhc_pkg and rhc_stream_if.
`default_nettype none

// Converts one 8-bit RGB pixel per clock into hue (degrees * 64, floor),
// saturation (floor of 255 * (max - min) / max) and value (max channel).
// Black pixels give hue 0, saturation 0 and hue_undefined set; gray pixels
// give hue 0. From input acceptance to the result being shown, a pixel goes
// through one sort stage, one dividend stage, twelve restoring divide
// stages (one hue quotient bit each; saturation's quotient bits only in the
// later ones) and one assembly stage that also serves as the output register.
// The whole pipeline advances whenever the output register is empty or taken,
// so a new item is accepted every cycle while the sink keeps up.
module rgb_to_hsv_converter_core
    import rhc_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    rhc_stream_if.sink   i_pix,
    rhc_stream_if.source o_hsv
);

    localparam int NDIV = HQ_W;
    localparam int NSTG = NDIV + 3;

    function automatic t_div div_step(input t_div d, input int b);
        t_div              o;
        logic [HREM_W-1:0] sh_h;
        logic [SREM_W-1:0] sh_s;
        o    = d;
        sh_h = HREM_W'(d.den_h) << b;
        sh_s = SREM_W'(d.den_s) << b;
        if (d.rem_h >= sh_h) begin
            o.rem_h = d.rem_h - sh_h;
            o.q_h[b] = 1'b1;
        end
        if (b < SQ_W) begin
            if (d.rem_s >= sh_s) begin
                o.rem_s = d.rem_s - sh_s;
                o.q_s[b % SQ_W] = 1'b1;
            end
        end
        return o;
    endfunction

    logic            en;
    logic [NSTG-1:0] r_vld;
    t_sort           r_sort;
    t_sort           n_sort;
    t_div            r_div [0:NDIV];
    t_div            n_div0;
    t_hsv            r_out;
    t_hsv            n_out;

    assign en          = !r_vld[NSTG-1] || o_hsv.ready;
    assign i_pix.ready = en;
    assign o_hsv.valid = r_vld[NSTG-1];
    assign o_hsv.data  = r_out;

    // sort: max, min, sector, signed hue difference
    always_comb begin
        logic [CH_W-1:0] r, g, b, mn;
        logic [CH_W:0]   diff;
        r = i_pix.data.red;
        g = i_pix.data.green;
        b = i_pix.data.blue;
        if (r >= g && r >= b) begin
            n_sort.sector = SEC_RED;
            n_sort.mx     = r;
            diff          = {1'b0, g} - {1'b0, b};
        end else if (g >= b) begin
            n_sort.sector = SEC_GREEN;
            n_sort.mx     = g;
            diff          = {1'b0, b} - {1'b0, r};
        end else begin
            n_sort.sector = SEC_BLUE;
            n_sort.mx     = b;
            diff          = {1'b0, r} - {1'b0, g};
        end
        mn = (r <= g) ? r : g;
        mn = (mn <= b) ? mn : b;
        n_sort.delta = n_sort.mx - mn;
        n_sort.neg   = diff[CH_W];
        n_sort.mag   = diff[CH_W] ? CH_W'(-diff) : diff[CH_W-1:0];
    end

    // dividends: mag * 3840 and delta * 255
    always_comb begin
        n_div0.rem_h  = {r_sort.mag, 12'd0} - {4'd0, r_sort.mag, 8'd0};
        n_div0.rem_s  = {r_sort.delta, 8'd0} - {8'd0, r_sort.delta};
        n_div0.q_h    = '0;
        n_div0.q_s    = '0;
        n_div0.den_h  = r_sort.delta;
        n_div0.den_s  = r_sort.mx;
        n_div0.neg    = r_sort.neg;
        n_div0.sector = r_sort.sector;
    end

    // hue assembly: floor of negative quotient is -(q + (rem != 0))
    always_comb begin
        t_div             d;
        logic [HUE_W-1:0] base;
        logic [HQ_W-1:0]  qc;
        logic             black;
        logic             flat;
        d     = r_div[NDIV];
        black = (d.den_s == '0);
        flat  = (d.den_h == '0);
        qc    = d.q_h + HQ_W'(d.rem_h != '0);
        unique case (d.sector)
            SEC_RED:   base = d.neg ? HUE_FULL : '0;
            SEC_GREEN: base = HUE_GREEN_BASE;
            SEC_BLUE:  base = HUE_BLUE_BASE;
            default:   base = '0;
        endcase
        if (flat) begin
            n_out.hue_deg_q6 = '0;
        end else if (d.neg) begin
            n_out.hue_deg_q6 = base - HUE_W'(qc);
        end else begin
            n_out.hue_deg_q6 = base + HUE_W'(d.q_h);
        end
        n_out.saturation    = black ? '0 : d.q_s;
        n_out.brightness    = d.den_s;
        n_out.hue_undefined = black;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NSTG-2:0], i_pix.valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sort   <= n_sort;
            r_div[0] <= n_div0;
            for (int j = 0; j < NDIV; j++) begin
                r_div[j+1] <= div_step(r_div[j], NDIV - 1 - j);
            end
            r_out <= n_out;
        end
    end

endmodule

`default_nettype wire
